@@ hw/rtl/edjd_pkg.sv @@
// shared types and status codes for the earliest finish job dispatcher
`default_nettype none

package edjd_pkg;

  localparam int TIME_W = 32;
  localparam int DUR_W  = 16;

  localparam logic MODE_LOAD     = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

  localparam logic [1:0] STAT_LOADED     = 2'd0;
  localparam logic [1:0] STAT_DISPATCHED = 2'd1;
  localparam logic [1:0] STAT_NONE       = 2'd2;
  localparam logic [1:0] STAT_FULL       = 2'd3;

  typedef struct packed {
    logic             mode;
    logic [3:0]       job_index;
    logic [3:0]       machine_id;
    logic [DUR_W-1:0] duration;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [3:0]        chosen_job;
    logic [3:0]        chosen_machine;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] total_completion;
  } out_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/edjd_stream_if.sv @@
// valid/ready stream channel carrying one payload per transfer
`default_nettype none

interface edjd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/earliest_finish_job_dispatcher.sv @@
// greedy earliest finish job shop dispatcher with a sequenced scan over job lists
// load item: status registered at the input transfer, then S_FIN moves it to the output register
// dispatch item: states S_SCAN, S_COMMIT, S_ACC (only when a job was found) and S_FIN in order;
//   a new input is taken only back in S_IDLE, and S_FIN waits while the output register is held;
//   one job enters the three stage scan (store read, start max, sat add and compare) per cycle
// result waits in an output register; synchronous active low reset clears counts, free times, sum
`default_nettype none

module earliest_finish_job_dispatcher
  import edjd_pkg::*;
#(
  parameter int MAX_JOBS        = 16,
  parameter int MAX_OPS_PER_JOB = 16,
  parameter int MAX_MACHINES    = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  edjd_stream_if.sink     in_if,
  edjd_stream_if.source   out_if,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_wdata
);

  localparam int JI        = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int JC        = $clog2(MAX_JOBS + 1);
  localparam int OW        = $clog2(MAX_OPS_PER_JOB + 1);
  localparam int MW        = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int OPS_DEPTH = MAX_JOBS * MAX_OPS_PER_JOB;
  localparam int AW        = (OPS_DEPTH > 1) ? $clog2(OPS_DEPTH) : 1;
  localparam int SUMW      = TIME_W + JI + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_COMMIT = 3'd2;
  localparam logic [2:0] S_ACC    = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0]        state_r;
  logic [4:0]        active_jobs_r;
  logic [JC-1:0]     n_r;
  logic [JC-1:0]     scan_j_r;

  logic [OW-1:0]     job_op_count_r [MAX_JOBS];
  logic [OW-1:0]     job_next_op_r  [MAX_JOBS];
  logic [TIME_W-1:0] job_free_r     [MAX_JOBS];
  logic [TIME_W-1:0] mach_free_r    [MAX_MACHINES];
  logic [SUMW-1:0]   sum_r;

  logic [MW-1:0]     op_mach_mem [OPS_DEPTH];
  logic [DUR_W-1:0]  op_dur_mem  [OPS_DEPTH];
  logic [MW-1:0]     rd_mach_r;
  logic [DUR_W-1:0]  rd_dur_r;

  logic [MW-1:0]     mod_tbl [16];

  // scan pipeline
  logic              p1_valid_r;
  logic [JI-1:0]     p1_job_r;
  logic [TIME_W-1:0] p1_jf_r;
  logic              p2_valid_r;
  logic [JI-1:0]     p2_job_r;
  logic [MW-1:0]     p2_mach_r;
  logic [TIME_W-1:0] p2_jf_r;
  logic [TIME_W-1:0] p2_start_r;
  logic [DUR_W-1:0]  p2_dur_r;

  logic              found_r;
  logic [JI-1:0]     best_job_r;
  logic [MW-1:0]     best_mach_r;
  logic [TIME_W-1:0] best_fin_r;
  logic [TIME_W-1:0] best_jf_r;
  logic [TIME_W-1:0] delta_r;

  logic [1:0]        res_status_r;
  logic [3:0]        res_job_r;
  logic [3:0]        res_mach_r;
  logic [TIME_W-1:0] res_fin_r;

  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              in_fire;
  logic [JI-1:0]     ld_job;
  logic [JI-1:0]     jidx;
  logic [OW-1:0]     cnt_sel;
  logic [OW-1:0]     next_sel;
  logic [TIME_W-1:0] jf_sel;
  logic              ld_reject;
  logic              issue;
  logic              pending;
  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  logic [TIME_W-1:0] mf_sel;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W:0]   fin_wide;
  logic [TIME_W-1:0] fin_sat;
  logic              better;
  logic [TIME_W-1:0] total_sat;
  logic              out_free;

  for (genvar v = 0; v < 16; v++) begin : g_mod
    assign mod_tbl[v] = MW'(v % MAX_MACHINES);
  end

  assign in_fire   = in_if.valid && in_if.ready;
  assign in_if.ready = rst_n && (state_r == S_IDLE);
  assign ld_job    = JI'(in_if.data.job_index);

  always_comb begin
    priority if (state_r == S_IDLE) begin
      jidx = ld_job;
    end else if (state_r == S_COMMIT) begin
      jidx = best_job_r;
    end else begin
      jidx = scan_j_r[JI-1:0];
    end
  end

  assign cnt_sel   = job_op_count_r[jidx];
  assign next_sel  = job_next_op_r[jidx];
  assign jf_sel    = job_free_r[jidx];
  assign ld_reject = (32'(in_if.data.job_index) >= MAX_JOBS)
                  || (32'(cnt_sel) >= MAX_OPS_PER_JOB);
  assign issue     = (state_r == S_SCAN) && (scan_j_r < n_r);
  assign pending   = next_sel < cnt_sel;
  assign mem_addr  = AW'(32'(jidx) * MAX_OPS_PER_JOB
                   + 32'((state_r == S_IDLE) ? cnt_sel : next_sel));
  assign mem_we    = in_fire && (in_if.data.mode == MODE_LOAD) && !ld_reject;

  assign mf_sel     = mach_free_r[rd_mach_r];
  assign start_time = (p1_jf_r > mf_sel) ? p1_jf_r : mf_sel;
  assign fin_wide   = {1'b0, p2_start_r} + {{(TIME_W + 1 - DUR_W){1'b0}}, p2_dur_r};
  assign fin_sat    = fin_wide[TIME_W] ? {TIME_W{1'b1}} : fin_wide[TIME_W-1:0];
  assign better     = !found_r || (fin_sat < best_fin_r);
  assign total_sat  = (|sum_r[SUMW-1:TIME_W]) ? {TIME_W{1'b1}} : sum_r[TIME_W-1:0];
  assign out_free   = !out_valid_r || out_if.ready;

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // operation store, one port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      op_mach_mem[mem_addr] <= mod_tbl[in_if.data.machine_id];
      op_dur_mem[mem_addr]  <= in_if.data.duration;
    end
    rd_mach_r <= op_mach_mem[mem_addr];
    rd_dur_r  <= op_dur_mem[mem_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    p1_job_r   <= jidx;
    p1_jf_r    <= jf_sel;
    p2_job_r   <= p1_job_r;
    p2_mach_r  <= rd_mach_r;
    p2_jf_r    <= p1_jf_r;
    p2_start_r <= start_time;
    p2_dur_r   <= rd_dur_r;
    if (p2_valid_r && better) begin
      best_job_r  <= p2_job_r;
      best_mach_r <= p2_mach_r;
      best_fin_r  <= fin_sat;
      best_jf_r   <= p2_jf_r;
    end
    if (state_r == S_COMMIT) begin
      delta_r <= best_fin_r - best_jf_r;
    end
    if (in_fire && (in_if.data.mode == MODE_LOAD)) begin
      res_status_r <= ld_reject ? STAT_FULL : STAT_LOADED;
      res_job_r    <= '0;
      res_mach_r   <= '0;
      res_fin_r    <= '0;
    end else if (state_r == S_COMMIT) begin
      res_status_r <= found_r ? STAT_DISPATCHED : STAT_NONE;
      res_job_r    <= found_r ? 4'(best_job_r) : 4'd0;
      res_mach_r   <= found_r ? 4'(best_mach_r) : 4'd0;
      res_fin_r    <= found_r ? best_fin_r : '0;
    end
    if ((state_r == S_FIN) && out_free) begin
      out_data_r.status           <= res_status_r;
      out_data_r.chosen_job       <= res_job_r;
      out_data_r.chosen_machine   <= res_mach_r;
      out_data_r.finish_time      <= res_fin_r;
      out_data_r.total_completion <= total_sat;
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      active_jobs_r <= 5'd16;
      n_r           <= '0;
      scan_j_r      <= '0;
      sum_r         <= '0;
      p1_valid_r    <= 1'b0;
      p2_valid_r    <= 1'b0;
      found_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int j = 0; j < MAX_JOBS; j++) begin
        job_op_count_r[j] <= '0;
        job_next_op_r[j]  <= '0;
        job_free_r[j]     <= '0;
      end
      for (int m = 0; m < MAX_MACHINES; m++) begin
        mach_free_r[m] <= '0;
      end
    end else begin
      if (cfg_we) begin
        active_jobs_r <= cfg_wdata;
      end
      p1_valid_r <= issue && pending;
      p2_valid_r <= p1_valid_r;
      if (p2_valid_r) begin
        found_r <= 1'b1;
      end
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_if.data.mode == MODE_LOAD) begin
              if (!ld_reject) begin
                job_op_count_r[ld_job] <= cnt_sel + OW'(1);
              end
              state_r <= S_FIN;
            end else begin
              n_r      <= (32'(active_jobs_r) > MAX_JOBS) ? JC'(MAX_JOBS) : JC'(active_jobs_r);
              scan_j_r <= '0;
              found_r  <= 1'b0;
              state_r  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_j_r <= scan_j_r + JC'(1);
          end else if (!p1_valid_r && !p2_valid_r) begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (found_r) begin
            mach_free_r[best_mach_r] <= best_fin_r;
            job_free_r[best_job_r]   <= best_fin_r;
            job_next_op_r[best_job_r] <= next_sel + OW'(1);
            state_r <= S_ACC;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_ACC: begin
          // free times only grow, so the exact sum tracks by the winner's increase
          sum_r   <= sum_r + SUMW'(delta_r);
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
